// ===== rtl/prle_pkg.sv =====
// Shared constants and types for the pixel run-length encoder.
`default_nettype none
package prle_pkg;

  localparam int COUNTER_WIDTH   = 6;
  localparam int COLLAPSED_LIMIT = 10;
  localparam int MAX_PIXEL_WIDTH = 8;

  localparam int PIXEL_W   = 8;
  localparam int BPP_W     = 4;
  localparam int CODE_W    = 33;
  localparam int CODE_LEN_W = 6;

  localparam int COUNTER_MAX = (1 << COUNTER_WIDTH) - 1;
  localparam int MAX_RUN     = COUNTER_MAX + COLLAPSED_LIMIT + 2;
  localparam int RUN_W       = $clog2(MAX_RUN + 1);

  localparam int BPP_RESET = 4;

  // One closed run waiting to be encoded.
  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic [RUN_W-1:0]   length;
    logic               last;
  } run_desc_t;

endpackage
`default_nettype wire

// ===== rtl/pixel_run_length_encoder_unit.sv =====
// Pixel run-length encoder: run tracking, closed-run queue and code word builder.
// Closed runs are written into the run queue; code words are built combinationally from its head.
// Throughput: one pixel per cycle while in_stall is low; the output port moves one word per cycle
//   while out_stall is low, so a pixel that closes two runs (value change plus end of data or cap) pushes two words.
// Input stall rises while the four-entry run queue holds more than two words.
// Reset (rst, synchronous): no open run, empty queue, bits_per_pixel = 4.
`default_nettype none
module pixel_run_length_encoder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [prle_pkg::BPP_W-1:0]        bits_per_pixel,
  // pixel input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [prle_pkg::PIXEL_W-1:0]      pixel,
  input  wire logic                              end_of_data,
  // code word output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [prle_pkg::CODE_W-1:0]            code,
  output logic [prle_pkg::CODE_LEN_W-1:0]        code_length,
  output logic                                   last
);
  import prle_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration
  logic [BPP_W-1:0] bpp;

  // open run
  logic [PIXEL_W-1:0] run_value, run_value_next;
  logic [RUN_W-1:0]   run_length, run_length_next;

  // closed-run queue
  run_desc_t          queue [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count, count_next;

  logic        in_beat, out_beat;
  logic        differ, close;
  logic [RUN_W-1:0] new_len;
  logic [PIXEL_W-1:0] new_val;
  run_desc_t   old_run, cur_run, first_run;
  logic        push_one, push_two;
  logic [1:0]  push_n;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count > QCNT_W'(QDEPTH - 2));
  assign in_beat   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_beat  = out_valid && !out_stall;

  // ---------------- run tracking ----------------
  // A differing pixel closes the open run; the run holding the new pixel
  // closes at the cap or at end of data.
  always_comb begin
    differ  = (run_length != '0) && (pixel != run_value);
    if ((run_length == '0) || differ) begin
      new_len = RUN_W'(1);
      new_val = pixel;
    end else begin
      new_len = run_length + RUN_W'(1);
      new_val = run_value;
    end
    close = (new_len >= RUN_W'(MAX_RUN)) || end_of_data;

    old_run.value  = run_value;
    old_run.length = run_length;
    old_run.last   = 1'b0;
    cur_run.value  = new_val;
    cur_run.length = new_len;
    cur_run.last   = end_of_data;

    first_run = differ ? old_run : cur_run;
    push_one  = in_beat && (differ || close);
    push_two  = in_beat && differ && close;
    push_n    = {push_two, push_one && !push_two};

    run_value_next  = run_value;
    run_length_next = run_length;
    if (in_beat) begin
      run_value_next  = new_val;
      run_length_next = close ? '0 : new_len;
    end

    count_next = count + QCNT_W'(push_n) - QCNT_W'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp        <= BPP_W'(BPP_RESET);
      run_value  <= '0;
      run_length <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bpp <= bits_per_pixel;
      end
      run_value  <= run_value_next;
      run_length <= run_length_next;
      count      <= count_next;
      if (push_two) begin
        wr_ptr <= wr_ptr + QPTR_W'(2);
      end else if (push_one) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (out_beat) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (push_one) begin
      queue[wr_ptr] <= first_run;
    end
    if (push_two) begin
      queue[wr_ptr + QPTR_W'(1)] <= cur_run;
    end
  end

  // ---------------- code word builder ----------------
  // Pixel written once (single-pixel runs) or twice, then unary length (short runs) or a run of ones
  // and a counter field (long runs). Earliest bit lands at the top.
  run_desc_t            head;
  logic [BPP_W-1:0]     w;
  logic [CODE_W-1:0]    pmask, p, pp, ones;
  logic [RUN_W-1:0]     len_m1, len_m2, cnt;

  always_comb begin
    head = queue[rd_ptr];
    if (bpp == '0) begin
      w = BPP_W'(1);
    end else if (bpp > BPP_W'(MAX_PIXEL_WIDTH)) begin
      w = BPP_W'(MAX_PIXEL_WIDTH);
    end else begin
      w = bpp;
    end
    pmask  = (CODE_W'(1) << w) - CODE_W'(1);
    p      = CODE_W'(head.value) & pmask;
    pp     = (p << w) | p;
    len_m1 = head.length - RUN_W'(1);
    len_m2 = head.length - RUN_W'(2);
    cnt    = head.length - RUN_W'(COLLAPSED_LIMIT + 2);
    ones   = '0;
    if (head.length < RUN_W'(2)) begin
      code        = p;
      code_length = CODE_LEN_W'(w);
    end else if (head.length <= RUN_W'(COLLAPSED_LIMIT + 1)) begin
      ones        = ((CODE_W'(1) << len_m2) - CODE_W'(1)) << 1;
      code        = (pp << len_m1) | ones;
      code_length = CODE_LEN_W'({w, 1'b0}) + CODE_LEN_W'(len_m1);
    end else begin
      ones        = ((CODE_W'(1) << (COLLAPSED_LIMIT + 1)) - CODE_W'(1)) << COUNTER_WIDTH;
      code        = (pp << (COLLAPSED_LIMIT + 1 + COUNTER_WIDTH)) | ones
                  | (CODE_W'(cnt) & ((CODE_W'(1) << COUNTER_WIDTH) - CODE_W'(1)));
      code_length = CODE_LEN_W'({w, 1'b0})
                  + CODE_LEN_W'(COLLAPSED_LIMIT + 1 + COUNTER_WIDTH);
    end
    last = head.last;
  end

endmodule
`default_nettype wire
